@@ design/multimode_svf_filter_defines.svh @@
// Assertion macros for the multimode SVF filter.
// Defining NO_ASSERTIONS turns every check into nothing.
`ifndef MULTIMODE_SVF_FILTER_DEFINES_SVH
`define MULTIMODE_SVF_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SVF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svf check failed");
`define SVF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svf check failed");
`else
`define SVF_ASSERT_IMP(label, ante, cons)
`define SVF_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ design/svf_pkg.sv @@
// Shared types, constants, saturation helpers and tanh ROM for the SVF filter.
// No dependencies.
`timescale 1ns / 1ps
package svf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int TANH_POINTS = 257;
  localparam int TANH_AW     = $clog2(TANH_POINTS);
  localparam int SEG_BITS    = $clog2(TANH_POINTS - 1);
  localparam int POS_SH      = FRAC_BITS - 2 - SEG_BITS;
  localparam int A_W         = 34;
  localparam int B_W         = 25;
  localparam int P_W         = A_W + B_W;

  // table step 16/(N-1) in Q0.32
  localparam logic [63:0] TANH_H = (64'd16 << 32) / 64'(TANH_POINTS - 1);

  // register indexes on the config port
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_A1    = 3'd1;
  localparam logic [2:0] REG_A2    = 3'd2;
  localparam logic [2:0] REG_A3    = 3'd3;
  localparam logic [2:0] REG_DAMP  = 3'd4;
  localparam logic [2:0] REG_GAIN  = 3'd5;
  localparam logic [2:0] REG_NORM  = 3'd6;

  localparam logic [2:0] MODE_LP12  = 3'd0;
  localparam logic [2:0] MODE_LP24  = 3'd1;
  localparam logic [2:0] MODE_HP    = 3'd2;
  localparam logic [2:0] MODE_BP    = 3'd3;
  localparam logic [2:0] MODE_NOTCH = 3'd4;

  localparam logic [15:0] GAIN_UNITY = 16'd2048;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLIP_MUL, ST_CLIP_POS, ST_ROM_LO, ST_ROM_HI, ST_INTERP_MUL,
    ST_INTERP, ST_NORM_MUL, ST_NORM, ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5,
    ST_HP_MUL, ST_HP, ST_FINAL
  } step_t;

  typedef struct packed {
    step_t step;
    logic  stage2;
    logic  load;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic clip_en;
    logic lp24;
  } status_t;

  typedef logic [TANH_POINTS-1:0][23:0] tanh_rom_t;

  // restoring division, only evaluated while the ROM constant is built
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= dvs) begin
        rem  = rem - dvs;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8i/(N-1)) in Q1.23, from an exp series and rounded powers
  function automatic tanh_rom_t build_tanh();
    tanh_rom_t t;
    logic [63:0] one, h, term, r, e, den;
    one  = 64'd1 << 32;
    h    = TANH_H;
    term = one;
    r    = one;
    e    = one;
    for (int n = 1; n <= 16; n++) begin
      term = div_u64((term * h) >> 32, 64'(n));
      if (n[0]) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i < TANH_POINTS; i++) begin
      den  = one + e;
      t[i] = 24'(div_u64(((one - e) << 23) + (den >> 1), den));
      e    = (e * r + (one >> 1)) >> 32;
    end
    return t;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

@@ design/multimode_svf_filter.sv @@
// Multimode SVF filter: one sample word in, one filtered word out.
// Each word runs the filter steps; soft clip adds clip steps, lp24 a second pass.
// Multiply steps share one multiplier; a new word is taken only when idle.
// A new word is taken while the previous result waits in the output register.
// Reset (synchronous, rst high): registers to defaults, filter states cleared.
`timescale 1ns / 1ps
module multimode_svf_filter (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] sample_out
  // config write channel, always ready
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import svf_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = sample_out;

  // sequencer: one multiply step per cycle
  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, states, config and the output word register
  svf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  ($signed(s_axis_tdata)),
    .cmd        (cmd),
    .status     (status),
    .sample_out (sample_out)
  );

endmodule

@@ design/svf_ctrl.sv @@
// Sequencer for the SVF filter: walks the multiply steps of one sample.
// Depends on svf_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "multimode_svf_filter_defines.svh"
module svf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  svf_pkg::status_t status,
  output svf_pkg::cmd_t    cmd
);
  import svf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CLIP_MUL, S_CLIP_POS, S_ROM_LO, S_ROM_HI, S_INTERP_MUL,
    S_INTERP, S_NORM_MUL, S_NORM, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5,
    S_HP_MUL, S_HP, S_FINAL
  } state_t;

  state_t state;
  logic   stage2;
  logic   out_free;
  step_t  step;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:       step = ST_IDLE;
      S_CLIP_MUL:   step = ST_CLIP_MUL;
      S_CLIP_POS:   step = ST_CLIP_POS;
      S_ROM_LO:     step = ST_ROM_LO;
      S_ROM_HI:     step = ST_ROM_HI;
      S_INTERP_MUL: step = ST_INTERP_MUL;
      S_INTERP:     step = ST_INTERP;
      S_NORM_MUL:   step = ST_NORM_MUL;
      S_NORM:       step = ST_NORM;
      S_F0:         step = ST_F0;
      S_F1:         step = ST_F1;
      S_F2:         step = ST_F2;
      S_F3:         step = ST_F3;
      S_F4:         step = ST_F4;
      S_F5:         step = ST_F5;
      S_HP_MUL:     step = ST_HP_MUL;
      S_HP:         step = ST_HP;
      S_FINAL:      step = ST_FINAL;
      default:      step = ST_IDLE;
    endcase
  end

  assign cmd.step     = step;
  assign cmd.stage2   = stage2;
  assign cmd.load     = in_ready && in_valid;
  assign cmd.out_load = (state == S_FINAL) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          stage2 <= 1'b0;
          if (in_valid) state <= status.clip_en ? S_CLIP_MUL : S_F0;
        end
        S_CLIP_MUL:   state <= S_CLIP_POS;
        S_CLIP_POS:   state <= S_ROM_LO;
        S_ROM_LO:     state <= S_ROM_HI;
        S_ROM_HI:     state <= S_INTERP_MUL;
        S_INTERP_MUL: state <= S_INTERP;
        S_INTERP:     state <= S_NORM_MUL;
        S_NORM_MUL:   state <= S_NORM;
        S_NORM:       state <= S_F0;
        S_F0:         state <= S_F1;
        S_F1:         state <= S_F2;
        S_F2:         state <= S_F3;
        S_F3:         state <= S_F4;
        S_F4:         state <= S_F5;
        S_F5:         state <= stage2 ? S_FINAL : S_HP_MUL;
        S_HP_MUL:     state <= S_HP;
        S_HP: begin
          if (status.lp24) begin
            stage2 <= 1'b1;
            state  <= S_F0;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SVF_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_valid || out_ready)
  `SVF_ASSERT_NXT(a_valid_after_load, cmd.out_load, out_valid)
  `SVF_ASSERT_IMP(a_stage2_lp24_only, stage2 && state != S_IDLE, status.lp24)

endmodule

@@ design/svf_datapath.sv @@
// Datapath for the SVF filter: config registers, shared multiplier,
// tanh ROM, filter states and output register. Depends on svf_pkg.
`timescale 1ns / 1ps
module svf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [23:0]                         cfg_data,
  input  logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_in,
  input  svf_pkg::cmd_t                       cmd,
  output svf_pkg::status_t                    status,
  output logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_out
);
  import svf_pkg::*;

  logic [2:0]  mode;
  logic [22:0] a1, a2, a3, norm;
  logic [23:0] damping;
  logic [15:0] gain;

  logic signed [SAMPLE_BITS-1:0] x, res;
  logic [SAMPLE_BITS-1:0] mag;
  logic signed [31:0] b1, l1, b2, l2, v1, v2, lp1, bsel, lsel, sin;
  logic signed [32:0] v3;
  logic signed [P_W-1:0] prod, acc, mul;
  logic signed [A_W-1:0] ma;
  logic signed [B_W-1:0] mb;
  logic signed [P_W:0] rsum, hsum;
  logic [P_W-1:0] usum;
  logic [SEG_BITS-1:0] idx;
  logic [15:0] frac;
  logic clip_sat;
  logic [23:0] rom_q, lo, y;
  logic signed [63:0] mval, hp;

  assign status.clip_en = gain > GAIN_UNITY;
  assign status.lp24    = (mode == MODE_LP24);

  assign mag  = x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x) : x;
  assign bsel = cmd.stage2 ? b2 : b1;
  assign lsel = cmd.stage2 ? l2 : l1;
  assign sin  = cmd.stage2 ? lp1 : 32'(x);

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      ST_CLIP_MUL:   begin ma = A_W'(mag);        mb = B_W'(gain);    end
      ST_INTERP_MUL: begin ma = A_W'(rom_q - lo); mb = B_W'(frac);    end
      ST_NORM_MUL:   begin ma = A_W'(y);          mb = B_W'(norm);    end
      ST_F0:         begin ma = A_W'(bsel);       mb = B_W'(a1);      end
      ST_F1:         begin ma = A_W'(v3);         mb = B_W'(a2);      end
      ST_F2:         begin ma = A_W'(bsel);       mb = B_W'(a2);      end
      ST_F3:         begin ma = A_W'(v3);         mb = B_W'(a3);      end
      ST_HP_MUL:     begin ma = A_W'(v1);         mb = B_W'(damping); end
      default:       begin ma = '0;               mb = '0;            end
    endcase
  end

  assign mul  = ma * mb;
  assign rsum = (P_W+1)'(acc) + (P_W+1)'(prod) + (P_W+1)'(64'sd1 <<< 21);
  assign hsum = (P_W+1)'(prod) + (P_W+1)'(64'sd1 <<< 21);
  assign usum = prod + P_W'(64'd1 << 21);
  assign mval = 64'(usum[P_W-1:22]);
  assign hp   = 64'(x) - 64'(hsum >>> 22) - 64'(v2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_LP12;
      a1      <= 23'd4194304;
      a2      <= '0;
      a3      <= '0;
      damping <= 24'd8388608;
      gain    <= GAIN_UNITY;
      norm    <= 23'd4194304;
      b1 <= '0; l1 <= '0; b2 <= '0; l2 <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: mode    <= cfg_data[2:0];
          REG_A1:   a1      <= cfg_data[22:0];
          REG_A2:   a2      <= cfg_data[22:0];
          REG_A3:   a3      <= cfg_data[22:0];
          REG_DAMP: damping <= cfg_data;
          REG_GAIN: gain    <= cfg_data[15:0];
          REG_NORM: norm    <= cfg_data[22:0];
          default: ;
        endcase
      end
      if (cmd.step == ST_F5) begin
        if (cmd.stage2) begin
          b2 <= sat32((64'(v1) <<< 1) - 64'(bsel));
          l2 <= sat32((64'(v2) <<< 1) - 64'(lsel));
        end else begin
          b1 <= sat32((64'(v1) <<< 1) - 64'(bsel));
          l1 <= sat32((64'(v2) <<< 1) - 64'(lsel));
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) x <= sample_in;
    if (cmd.out_load) sample_out <= status.lp24 ? sat_smp(64'(v2)) : res;
    case (cmd.step)
      ST_CLIP_MUL: prod <= mul;
      ST_CLIP_POS: begin
        // table position, 16 fraction bits
        clip_sat <= |prod[P_W-1:POS_SH+16+SEG_BITS];
        idx      <= prod[POS_SH+16 +: SEG_BITS];
        frac     <= prod[POS_SH +: 16];
      end
      ST_ROM_LO: rom_q <= TANH_ROM[TANH_AW'(idx)];
      ST_ROM_HI: begin
        lo    <= rom_q;
        rom_q <= TANH_ROM[TANH_AW'(idx) + TANH_AW'(1)];
      end
      ST_INTERP_MUL: prod <= mul;
      ST_INTERP: y <= clip_sat ? 24'h800000 : lo + 24'(prod[39:16] + 24'(prod[15]));
      ST_NORM_MUL: prod <= mul;
      ST_NORM: x <= sat_smp(x[SAMPLE_BITS-1] ? -mval : mval);
      ST_F0: begin
        prod <= mul;
        v3   <= 33'(sin) - 33'(lsel);
      end
      ST_F1: begin acc <= prod; prod <= mul; end
      ST_F2: begin
        v1   <= sat32(64'(rsum >>> 22));
        prod <= mul;
      end
      ST_F3: begin acc <= prod; prod <= mul; end
      ST_F4: v2 <= sat32(64'(lsel) + 64'(rsum >>> 22));
      ST_HP_MUL: prod <= mul;
      ST_HP: begin
        lp1 <= v2;
        case (mode)
          MODE_LP12:  res <= sat_smp(64'(v2));
          MODE_HP:    res <= sat_smp(hp);
          MODE_BP:    res <= sat_smp(64'(v1));
          MODE_NOTCH: res <= sat_smp(hp + 64'(v2));
          default:    res <= x;
        endcase
      end
      default: ;
    endcase
  end

endmodule
